[rtl/core/ising_metropolis_spin_update_assert.svh]
// Assertion macros shared by the spin update modules.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_ASSERT_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_ASSERT_SVH

// Same-cycle implication, checked out of reset; expects clk and rst_n in scope.
`define ISU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("isu assertion failed");

// Next-cycle implication, checked out of reset; expects clk and rst_n in scope.
`define ISU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("isu assertion failed");

`endif

[rtl/core/isu_pkg.sv]
// Shared types, constants and command structs of the spin update block.
package isu_pkg;

    // Side of the square lattice; a power of two so row and column are bit fields.
    localparam int GRID_SIDE  = 256;
    localparam int ROW_W      = $clog2(GRID_SIDE);
    localparam int ADDR_W     = 2 * ROW_W;
    localparam int SITE_COUNT = GRID_SIDE * GRID_SIDE;

    localparam int SITE_W     = 16;
    localparam int RAND_W     = 16;
    localparam int THRESH_W   = 16;
    localparam int DE_W       = 5;
    localparam int IN_TDATA_W = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int IN_TUSER_W = 2;

    typedef enum logic [1:0] {
        MODE_ATTEMPT = 2'd0,
        MODE_WRITE   = 2'd1,
        MODE_READ    = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic [0:0] {
        CFG_THRESH_DE4 = 1'b0,
        CFG_THRESH_DE8 = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        RD_SITE  = 3'd0,
        RD_UP    = 3'd1,
        RD_DOWN  = 3'd2,
        RD_LEFT  = 3'd3,
        RD_RIGHT = 3'd4
    } rd_sel_t;

    typedef struct packed {
        logic    load_item;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_en;
        logic    commit;
    } isu_cmd_t;

    typedef struct packed {
        logic out_free;
    } isu_status_t;

endpackage

[rtl/core/isu_ctrl.sv]
// Sequencer that walks the five lattice reads and the commit of one request.
module isu_ctrl
    import isu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output isu_cmd_t    cmd,
    input  isu_status_t status
);

`include "ising_metropolis_spin_update_assert.svh"

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_RD_SITE  = 8'b0000_0010,
        S_RD_UP    = 8'b0000_0100,
        S_RD_DOWN  = 8'b0000_1000,
        S_RD_LEFT  = 8'b0001_0000,
        S_RD_RIGHT = 8'b0010_0000,
        S_CAP_LAST = 8'b0100_0000,
        S_COMMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.load_item = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.rd_sel    = RD_SITE;
        cmd.cap_en    = 1'b0;
        cmd.commit    = 1'b0;
        s_tready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_RD_SITE;
                end
            end
            S_RD_SITE:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SITE;
                state_next = S_RD_UP;
            end
            S_RD_UP:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_UP;
                cmd.cap_en = 1'b1;
                state_next = S_RD_DOWN;
            end
            S_RD_DOWN:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_DOWN;
                cmd.cap_en = 1'b1;
                state_next = S_RD_LEFT;
            end
            S_RD_LEFT:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LEFT;
                cmd.cap_en = 1'b1;
                state_next = S_RD_RIGHT;
            end
            S_RD_RIGHT:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_RIGHT;
                cmd.cap_en = 1'b1;
                state_next = S_CAP_LAST;
            end
            S_CAP_LAST:
            begin
                cmd.cap_en = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the output register can take the result
                cmd.commit = status.out_free;
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ISU_ASSERT_IMPL(a_read_walk_len, state_reg == S_RD_SITE, ##6 (state_reg == S_COMMIT))
    `ISU_ASSERT_NEXT(a_commit_to_idle, cmd.commit, (state_reg == S_IDLE))
    `ISU_ASSERT_NEXT(a_accept_starts, cmd.load_item, (state_reg == S_RD_SITE))

endmodule

[rtl/core/isu_datapath.sv]
// Spin memory, neighbour addressing, Metropolis decision and output register.
module isu_datapath
    import isu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [THRESH_W-1:0]    cfg_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  isu_cmd_t               cmd,
    output isu_status_t            status
);

`include "ising_metropolis_spin_update_assert.svh"

    logic [THRESH_W-1:0] thresh_de4_reg;
    logic [THRESH_W-1:0] thresh_de8_reg;

    mode_t             mode_reg;
    logic [SITE_W-1:0] site_reg;
    logic [RAND_W-1:0] rand_reg;
    logic              wr_spin_reg;

    logic              mem [SITE_COUNT];
    logic              rdata_reg;
    logic [4:0]        nb_reg;
    logic [4:0]        nb_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    logic [ROW_W-1:0]  row_up;
    logic [ROW_W-1:0]  row_down;
    logic [ROW_W-1:0]  col_left;
    logic [ROW_W-1:0]  col_right;
    logic [ADDR_W-1:0] site_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              site_ok;

    logic              spin_old;
    logic [2:0]        match_cnt;
    logic [DE_W-1:0]   de;
    logic              keep;
    logic              res_acc;
    logic              res_spin;
    logic [DE_W-1:0]   res_de;
    logic              mem_we;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_de4_reg <= '0;
            thresh_de8_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_THRESH_DE4: thresh_de4_reg <= cfg_data;
                CFG_THRESH_DE8: thresh_de8_reg <= cfg_data;
                default:        thresh_de4_reg <= thresh_de4_reg;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg    <= mode_t'(s_tuser);
            site_reg    <= s_tdata[SITE_W-1:0];
            rand_reg    <= s_tdata[SITE_W +: RAND_W];
            wr_spin_reg <= s_tdata[SITE_W + RAND_W];
        end
    end

    // toroidal neighbour addresses
    always_comb
    begin
        site_addr = site_reg[ADDR_W-1:0];
        site_ok   = ({1'b0, site_reg} < (SITE_W + 1)'(SITE_COUNT));
        row       = site_addr[ADDR_W-1:ROW_W];
        col       = site_addr[ROW_W-1:0];
        row_up    = (row == '0) ? ROW_W'(GRID_SIDE - 1) : row - 1'b1;
        row_down  = (row == ROW_W'(GRID_SIDE - 1)) ? '0 : row + 1'b1;
        col_left  = (col == '0) ? ROW_W'(GRID_SIDE - 1) : col - 1'b1;
        col_right = (col == ROW_W'(GRID_SIDE - 1)) ? '0 : col + 1'b1;
        case (cmd.rd_sel)
            RD_SITE:  rd_addr = site_addr;
            RD_UP:    rd_addr = {row_up, col};
            RD_DOWN:  rd_addr = {row_down, col};
            RD_LEFT:  rd_addr = {row, col_left};
            RD_RIGHT: rd_addr = {row, col_right};
            default:  rd_addr = site_addr;
        endcase
    end

    // spin memory: one read and one write port, registered read data
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (mem_we)
        begin
            mem[site_addr] <= res_spin;
        end
    end

    // shift the read spins in: site, up, down, left, right from bit 0 up
    assign nb_next = {rdata_reg, nb_reg[4:1]};

    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            nb_reg <= nb_next;
        end
    end

    // energy change is 4 * (neighbours equal to the site) - 8
    always_comb
    begin
        spin_old  = nb_reg[0];
        match_cnt = {2'b00, nb_reg[1] ~^ spin_old} + {2'b00, nb_reg[2] ~^ spin_old}
                  + {2'b00, nb_reg[3] ~^ spin_old} + {2'b00, nb_reg[4] ~^ spin_old};
        de        = {match_cnt, 2'b00} - DE_W'(8);
        case (match_cnt)
            3'd3:    keep = (rand_reg < thresh_de4_reg);
            3'd4:    keep = (rand_reg < thresh_de8_reg);
            default: keep = 1'b1;
        endcase

        res_acc  = 1'b0;
        res_spin = 1'b0;
        res_de   = '0;
        mem_we   = 1'b0;
        if (site_ok)
        begin
            case (mode_reg)
                MODE_ATTEMPT:
                begin
                    res_acc  = keep;
                    res_spin = spin_old ^ keep;
                    res_de   = de;
                    mem_we   = cmd.commit & keep;
                end
                MODE_WRITE:
                begin
                    res_spin = wr_spin_reg;
                    mem_we   = cmd.commit;
                end
                MODE_READ:
                begin
                    res_spin = spin_old;
                end
                default:
                begin
                    res_spin = 1'b0;
                end
            endcase
        end
    end

    // output register
    assign status.out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        out_data_next = {1'b0, res_de, res_spin, res_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ISU_ASSERT_NEXT(a_commit_loads, cmd.commit, (out_valid_reg && (out_data_reg[3:2] == 2'b00)))
    `ISU_ASSERT_IMPL(a_commit_room, cmd.commit && out_valid_reg, m_tready)
    `ISU_ASSERT_NEXT(a_accept_flips, cmd.commit && mode_reg == MODE_ATTEMPT && site_ok && keep, (out_data_reg[1] != $past(nb_reg[0])))

endmodule

[rtl/core/ising_metropolis_spin_update.sv]
// Top level of the 2-D Ising Metropolis spin update block.
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       s_tuser mode, s_tdata site/random/spin
//  m_*       out  m_tvalid / m_tready       m_tdata accepted/spin_now/energy_change
//  cfg_*     in   cfg_valid / cfg_ready     cfg_index, cfg_data (thresholds)
//
// After acceptance, the single read port of the spin memory walks the site
// and its four wrapped neighbours one a cycle, then the decision and the
// write-back share the commit cycle.
// A request is taken while an earlier result still waits in the output register;
// only the commit waits for m_tready.
// rst_n clears the controller, the output valid and both thresholds; the
// lattice is not cleared and must be loaded with write requests before use.
// cfg_ready is always high; write thresholds only while no request is in flight.
module ising_metropolis_spin_update
    import isu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [15:0] site_index, [31:16] random_fraction, [32] spin_value, [39:33] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] accepted, [1] spin_now, [6:2] energy_change, [7] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [THRESH_W-1:0]    cfg_data
);

    isu_cmd_t    cmd;
    isu_status_t status;

    // thresholds are plain registers, so every write lands at once
    assign cfg_ready = 1'b1;

    isu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    isu_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[tb/ising_metropolis_spin_update_checker.sv]
// Checker for the spin update block: predicts each request's result and compares it.
`timescale 1ns / 1ps

module ising_metropolis_spin_update_checker
    import isu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // [15:0] site_index, [31:16] random_fraction, [32] spin_value, [39:33] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] accepted, [1] spin_now, [6:2] energy_change, [7] zero
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [THRESH_W-1:0]    cfg_data,
    output int unsigned            mismatch_total,
    output int unsigned            results_owed
);

    typedef struct packed {
        logic                   accepted;
        logic                   spin_now;
        logic signed [DE_W-1:0] energy_change;
    } spin_outcome_t;

    bit                  shadow_lattice [SITE_COUNT];
    logic [THRESH_W-1:0] bound_de4 = '0;
    logic [THRESH_W-1:0] bound_de8 = '0;
    spin_outcome_t       owed_outcomes [$];

    function automatic int spin_sign(input int site);
        return shadow_lattice[site] ? 1 : -1;
    endfunction

    // Energy change of flipping one spin, with toroidal wrap on both axes.
    function automatic int flip_energy(input int site);
        int row;
        int col;
        int up;
        int down;
        int w_col;
        int e_col;
        int neighbours;
        row   = site / GRID_SIDE;
        col   = site % GRID_SIDE;
        up    = (row == 0) ? GRID_SIDE - 1 : row - 1;
        down  = (row == GRID_SIDE - 1) ? 0 : row + 1;
        w_col = (col == 0) ? GRID_SIDE - 1 : col - 1;
        e_col = (col == GRID_SIDE - 1) ? 0 : col + 1;
        neighbours = spin_sign(up * GRID_SIDE + col) + spin_sign(down * GRID_SIDE + col)
                   + spin_sign(row * GRID_SIDE + w_col) + spin_sign(row * GRID_SIDE + e_col);
        return 2 * spin_sign(site) * neighbours;
    endfunction

    function automatic spin_outcome_t apply_request(input mode_t mode,
                                                   input logic [SITE_W-1:0] site,
                                                   input logic [RAND_W-1:0] fraction,
                                                   input logic spin_value);
        spin_outcome_t outcome;
        int            de;
        bit            keep;
        int            idx;
        outcome = '0;
        idx     = site;
        if (idx < SITE_COUNT)
        begin
            case (mode)
                MODE_ATTEMPT:
                begin
                    de = flip_energy(idx);
                    if (de <= 0)
                        keep = 1'b1;
                    else if (de == 4)
                        keep = fraction < bound_de4;
                    else
                        keep = fraction < bound_de8;
                    if (keep)
                        shadow_lattice[idx] = ~shadow_lattice[idx];
                    outcome.accepted      = keep;
                    outcome.spin_now      = shadow_lattice[idx];
                    outcome.energy_change = de[DE_W-1:0];
                end
                MODE_WRITE:
                begin
                    shadow_lattice[idx] = spin_value;
                    outcome.spin_now    = spin_value;
                end
                MODE_READ:
                    outcome.spin_now = shadow_lattice[idx];
                default:
                    outcome = '0;
            endcase
        end
        return outcome;
    endfunction

    always @(posedge clk)
    begin
        spin_outcome_t got;
        spin_outcome_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_THRESH_DE4)
                    bound_de4 = cfg_data;
                else
                    bound_de8 = cfg_data;
            end

            // drain the result side first so a same-edge request never pairs with itself
            if (m_tvalid && m_tready)
            begin
                got.accepted      = m_tdata[0];
                got.spin_now      = m_tdata[1];
                got.energy_change = m_tdata[2 +: DE_W];
                if (owed_outcomes.size() == 0)
                begin
                    if (mismatch_total < 10)
                        $display("[%0t] result with none owed: acc %b spin %b de %0d",
                                 $realtime, got.accepted, got.spin_now,
                                 $signed(got.energy_change));
                    mismatch_total++;
                end
                else
                begin
                    want = owed_outcomes.pop_front();
                    if (got.accepted !== want.accepted || got.spin_now !== want.spin_now
                        || got.energy_change !== want.energy_change)
                    begin
                        if (mismatch_total < 10)
                            $display("[%0t] result mismatch: acc %b/%b spin %b/%b de %0d/%0d",
                                     $realtime, want.accepted, got.accepted, want.spin_now,
                                     got.spin_now, $signed(want.energy_change),
                                     $signed(got.energy_change));
                        mismatch_total++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                owed_outcomes.push_back(apply_request(mode_t'(s_tuser[1:0]),
                                                      s_tdata[SITE_W-1:0],
                                                      s_tdata[SITE_W +: RAND_W],
                                                      s_tdata[SITE_W + RAND_W]));

            results_owed = owed_outcomes.size();
        end
        else
        begin
            mismatch_total = 0;
            results_owed   = 0;
        end
    end

endmodule

[tb/ising_metropolis_spin_update_test.sv]
// Top of the spin update regression: clock, reset, request and threshold stimulus, verdict.
`timescale 1ns / 1ps

module ising_metropolis_spin_update_test
    import isu_pkg::*;
();

    // Counted requests (modes 0..2) spread over the random phases.
    localparam int ITEM_TARGET  = 500;
    localparam int RANDOM_PHASES = 5;
    localparam rd_sel_t COMPASS [4] = '{RD_UP, RD_DOWN, RD_LEFT, RD_RIGHT};

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // [15:0] site_index, [31:16] random_fraction, [32] spin_value, [39:33] zero
    logic [IN_TDATA_W-1:0]  s_tdata;
    // [1:0] mode
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [0] accepted, [1] spin_now, [6:2] energy_change, [7] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_index;
    logic [THRESH_W-1:0]    cfg_data;

    int unsigned mismatch_total;
    int unsigned results_owed;

    // Sites written so far: attempts and reads only ever touch these, since the
    // lattice holds nothing defined until it has been loaded.
    bit                  site_loaded [SITE_COUNT];
    logic [THRESH_W-1:0] live_de4;
    logic [THRESH_W-1:0] live_de8;
    int unsigned         counted_items;
    int unsigned         tx_calm_left;
    int unsigned         rx_stall_left = 0;
    int unsigned         rx_calm_left = 0;

    ising_metropolis_spin_update u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ising_metropolis_spin_update_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_total (mismatch_total),
        .results_owed   (results_owed)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Mostly short idle spells, now and then a long one.
    function automatic int unsigned idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Wrapped neighbour of a site in the given direction.
    function automatic int torus_neighbour(input int site, input rd_sel_t dir);
        int row;
        int col;
        row = site / GRID_SIDE;
        col = site % GRID_SIDE;
        case (dir)
            RD_UP:    row = (row + GRID_SIDE - 1) % GRID_SIDE;
            RD_DOWN:  row = (row + 1) % GRID_SIDE;
            RD_LEFT:  col = (col + GRID_SIDE - 1) % GRID_SIDE;
            default:  col = (col + 1) % GRID_SIDE;
        endcase
        return row * GRID_SIDE + col;
    endfunction

    // Cluster most sites around the wrapping corner so neighbourhoods overlap
    // and earlier flips feed later attempts; the rest land anywhere.
    function automatic int pick_site();
        int row;
        int col;
        if ($urandom_range(0, 99) < 20)
            return $urandom_range(0, SITE_COUNT - 1);
        row = (GRID_SIDE - 4 + $urandom_range(0, 7)) % GRID_SIDE;
        col = (GRID_SIDE - 4 + $urandom_range(0, 7)) % GRID_SIDE;
        return row * GRID_SIDE + col;
    endfunction

    // Random fraction, often hugging a live threshold or the range ends.
    function automatic logic [RAND_W-1:0] pick_fraction();
        logic [THRESH_W-1:0] bound;
        int                  roll;
        roll  = $urandom_range(0, 99);
        bound = $urandom_range(0, 1) ? live_de4 : live_de8;
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        if (roll < 50)
            return bound + RAND_W'($urandom_range(0, 2)) - 1'b1;
        return RAND_W'($urandom_range(0, 65535));
    endfunction

    // Offer one request, with a random lead-in gap, and hold it until taken.
    task automatic send_request(input mode_t mode, input int site,
                                input logic [RAND_W-1:0] fraction, input logic spin_value);
        logic [IN_TDATA_W-1:0] word;
        int unsigned           gap;
        int                    roll;
        word = '0;
        word[SITE_W-1:0]         = site[SITE_W-1:0];
        word[SITE_W +: RAND_W]   = fraction;
        word[SITE_W + RAND_W]    = spin_value;
        gap  = 0;
        if (tx_calm_left > 0)
            tx_calm_left--;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                tx_calm_left = $urandom_range(20, 60);
            else if (roll >= 55)
                gap = idle_length();
        end
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= word;
        do @(posedge clk); while (s_tready !== 1'b1);
        if (mode == MODE_WRITE)
            site_loaded[site] = 1'b1;
        if (mode != MODE_UNUSED)
            counted_items++;
    endtask

    // Load a site with a random spin unless it already holds one.
    task automatic load_site(input int site);
        if (!site_loaded[site])
            send_request(MODE_WRITE, site, RAND_W'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)));
    endtask

    // Drop the request valid and wait until every owed result has come back.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_owed != 0) @(negedge clk);
    endtask

    task automatic write_threshold(input cfg_index_t idx, input logic [THRESH_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_THRESH_DE4)
            live_de4 = value;
        else
            live_de8 = value;
    endtask

    // Result side: ready mostly high, stalled in random spells, with calm stretches.
    always @(negedge clk)
    begin
        if (rx_stall_left > 0)
        begin
            m_tready <= 1'b0;
            rx_stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            if (rx_calm_left > 0)
                rx_calm_left--;
            else if ($urandom_range(0, 99) < 4)
                rx_calm_left = $urandom_range(30, 80);
            else if ($urandom_range(0, 99) < 30)
                rx_stall_left = idle_length();
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned phase_start;
        int          site;
        int          roll;

        // Drive every input to a known value before the first edge.
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = 1'b0;
        cfg_data      = '0;
        live_de4      = '0;
        live_de8      = '0;
        counted_items = 0;
        tx_calm_left  = 0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, both thresholds at zero so no positive change is kept.
        write_threshold(CFG_THRESH_DE4, '0);
        write_threshold(CFG_THRESH_DE8, '0);

        // Corner site 0 and its wrapped neighbours, all up: change +8, refused.
        send_request(MODE_WRITE, 0, '0, 1'b1);
        send_request(MODE_WRITE, 1, '0, 1'b1);
        send_request(MODE_WRITE, GRID_SIDE - 1, '0, 1'b1);
        send_request(MODE_WRITE, GRID_SIDE, '0, 1'b1);
        send_request(MODE_WRITE, SITE_COUNT - GRID_SIDE, '0, 1'b1);
        send_request(MODE_ATTEMPT, 0, '0, 1'b0);
        send_request(MODE_READ, 0, '1, 1'b1);
        // One neighbour down: change +4, still refused at zero threshold.
        send_request(MODE_WRITE, 1, '1, 1'b0);
        send_request(MODE_ATTEMPT, 0, '0, 1'b1);
        // Balanced neighbours: zero change always flips, even at the top fraction.
        send_request(MODE_WRITE, GRID_SIDE - 1, '0, 1'b0);
        send_request(MODE_ATTEMPT, 0, '1, 1'b0);
        send_request(MODE_ATTEMPT, 0, '1, 1'b1);
        // All neighbours down against an up spin: change -8, kept; then +8, refused.
        send_request(MODE_WRITE, GRID_SIDE, '0, 1'b0);
        send_request(MODE_WRITE, SITE_COUNT - GRID_SIDE, '0, 1'b0);
        send_request(MODE_ATTEMPT, 0, '1, 1'b0);
        send_request(MODE_ATTEMPT, 0, '0, 1'b0);
        // Far corner, wrapping on both axes: change -4.
        send_request(MODE_WRITE, SITE_COUNT - 1, '1, 1'b1);
        send_request(MODE_WRITE, SITE_COUNT - 1 - GRID_SIDE, '0, 1'b1);
        send_request(MODE_WRITE, SITE_COUNT - 2, '0, 1'b0);
        send_request(MODE_ATTEMPT, SITE_COUNT - 1, '1, 1'b1);
        send_request(MODE_READ, SITE_COUNT - 1, '0, 1'b0);
        // Unused mode: answered with zeros, lattice untouched.
        send_request(MODE_UNUSED, SITE_COUNT - 1, '1, 1'b1);
        send_request(MODE_UNUSED, 0, '0, 1'b0);

        for (phase = 1; phase <= RANDOM_PHASES; phase++)
        begin
            // Thresholds move only with nothing in flight.
            drain_results();
            case (phase)
                1:
                begin
                    write_threshold(CFG_THRESH_DE4, '1);
                    write_threshold(CFG_THRESH_DE8, '1);
                end
                2:
                begin
                    write_threshold(CFG_THRESH_DE8, 16'h2000);
                    write_threshold(CFG_THRESH_DE4, 16'h8000);
                end
                4:
                begin
                    write_threshold(CFG_THRESH_DE4, '1);
                    write_threshold(CFG_THRESH_DE8, '0);
                end
                default:
                begin
                    write_threshold(CFG_THRESH_DE4, THRESH_W'($urandom_range(0, 65535)));
                    write_threshold(CFG_THRESH_DE8, THRESH_W'($urandom_range(0, 65535)));
                end
            endcase

            phase_start = counted_items;
            while (counted_items - phase_start < ITEM_TARGET / RANDOM_PHASES)
            begin
                roll = $urandom_range(0, 99);
                site = pick_site();
                if (roll < 8)
                    send_request(MODE_UNUSED, $urandom_range(0, SITE_COUNT - 1),
                                 RAND_W'($urandom_range(0, 65535)),
                                 1'($urandom_range(0, 1)));
                else if (roll < 62)
                begin
                    // Attempt: make sure the site and its four neighbours hold spins.
                    load_site(site);
                    for (int k = 0; k < 4; k++)
                        load_site(torus_neighbour(site, COMPASS[k]));
                    send_request(MODE_ATTEMPT, site, pick_fraction(),
                                 1'($urandom_range(0, 1)));
                end
                else if (roll < 76)
                begin
                    load_site(site);
                    send_request(MODE_READ, site, RAND_W'($urandom_range(0, 65535)),
                                 1'($urandom_range(0, 1)));
                end
                else
                    send_request(MODE_WRITE, site, RAND_W'($urandom_range(0, 65535)),
                                 1'($urandom_range(0, 1)));
            end
        end

        // Let the last results come home, then wait a while for stray output.
        drain_results();
        repeat (20) @(negedge clk);
        if (mismatch_total == 0 && results_owed == 0)
            $display("ising_metropolis_spin_update regression: pass");
        else
            $display("ising_metropolis_spin_update regression: fail");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("ising_metropolis_spin_update regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/isu_pkg.sv
rtl/core/isu_ctrl.sv
rtl/core/isu_datapath.sv
rtl/core/ising_metropolis_spin_update.sv
tb/ising_metropolis_spin_update_checker.sv
tb/ising_metropolis_spin_update_test.sv
